// ----- hw/rtl/ted_pkg.sv -----
// shared types, codes and per-byte update functions for the text encoding detector
package ted_pkg;

	localparam logic [2:0] ENC_UNKNOWN  = 3'd0;
	localparam logic [2:0] ENC_SJIS     = 3'd1;
	localparam logic [2:0] ENC_UTF8     = 3'd2;
	localparam logic [2:0] ENC_UTF8_BOM = 3'd3;
	localparam logic [2:0] ENC_LE_BOM   = 3'd4;
	localparam logic [2:0] ENC_BE_BOM   = 3'd5;
	localparam logic [2:0] ENC_LE_GUESS = 3'd6;
	localparam logic [2:0] ENC_BE_GUESS = 3'd7;

	localparam logic [1:0] NL_NONE = 2'd0;
	localparam logic [1:0] NL_CRLF = 2'd1;
	localparam logic [1:0] NL_CR   = 2'd2;
	localparam logic [1:0] NL_LF   = 2'd3;

	localparam logic [1:0] BOM_NONE = 2'd0;
	localparam logic [1:0] BOM_LE   = 2'd1;
	localparam logic [1:0] BOM_BE   = 2'd2;
	localparam logic [1:0] BOM_UTF8 = 2'd3;

	localparam logic [1:0] HINT_NONE = 2'd0;
	localparam logic [1:0] HINT_LE   = 2'd1;
	localparam logic [1:0] HINT_BE   = 2'd2;

	localparam logic [7:0] BYTE_LF = 8'h0a;
	localparam logic [7:0] BYTE_CR = 8'h0d;

	typedef struct packed {
		logic [23:0] head;
		logic [1:0]  cnt;
		logic [1:0]  bom;
		logic        sjis_ok;
		logic        sjis_wait;
		logic        utf8_ok;
		logic [1:0]  utf8_left;
		logic        nl_done;
		logic [1:0]  nl_kind;
		logic [23:0] cr_la;
		logic [1:0]  cr_cnt;
		logic        cr_pend;
		logic        cr_odd;
		logic        cr_pz;
		logic [1:0]  hint;
		logic        parity;
		logic        prev_zero;
	} det_state_t;

	typedef struct packed {
		logic       detected;
		logic [2:0] encoding;
		logic [1:0] newline_type;
	} result_t;

	function automatic det_state_t state_reset();
		det_state_t st;
		st = '0;
		st.sjis_ok = 1'b1;
		st.utf8_ok = 1'b1;
		return st;
	endfunction

	// settle a pending CR once enough following bytes are known
	function automatic det_state_t cr_resolve(det_state_t st_in, logic fin);
		det_state_t st;
		logic [7:0] n1;
		logic [7:0] n2;
		logic [7:0] n3;
		logic [1:0] kind;
		logic [1:0] hint;
		logic       decided;
		st = st_in;
		n1 = st.cr_la[7:0];
		n2 = st.cr_la[15:8];
		n3 = st.cr_la[23:16];
		kind = NL_NONE;
		hint = HINT_NONE;
		decided = 1'b0;
		if (st.cr_pend) begin
			if (st.cr_cnt >= 2'd1 && n1 == BYTE_LF) begin
				kind = NL_CRLF;
				decided = 1'b1;
			end else if (st.cr_cnt >= 2'd2 && n1 == 8'h00 && n2 == BYTE_LF) begin
				kind = NL_CRLF;
				if (st.cr_odd) begin
					hint = st.cr_pz ? HINT_BE : HINT_NONE;
					decided = 1'b1;
				end else if (st.cr_cnt == 2'd3) begin
					hint = (n3 == 8'h00) ? HINT_LE : HINT_NONE;
					decided = 1'b1;
				end else if (fin) begin
					decided = 1'b1;
				end
			end else if ((st.cr_cnt == 2'd0 || (st.cr_cnt == 2'd1 && n1 == 8'h00)) && !fin) begin
				decided = 1'b0;
			end else begin
				kind = NL_CR;
				if (st.cr_odd)
					hint = st.cr_pz ? HINT_BE : HINT_NONE;
				else
					hint = (st.cr_cnt >= 2'd1 && n1 == 8'h00) ? HINT_LE : HINT_NONE;
				decided = 1'b1;
			end
			if (decided) begin
				st.nl_kind = kind;
				st.hint = hint;
				st.cr_pend = 1'b0;
				st.cr_odd = 1'b0;
				st.cr_pz = 1'b0;
			end
		end
		return st;
	endfunction

	// one body byte through both validators and the newline finder
	function automatic det_state_t body_feed(det_state_t st_in, logic [7:0] b);
		det_state_t st;
		st = st_in;
		if (st.sjis_wait) begin
			st.sjis_wait = 1'b0;
			if (b < 8'h40 || b == 8'h7f || b > 8'hfc)
				st.sjis_ok = 1'b0;
		end else if (b == 8'h00 || b inside {[8'ha1:8'hdf]}) begin
			st.sjis_ok = 1'b0;
		end else if (b inside {[8'h81:8'h9f], [8'he0:8'hfc]}) begin
			st.sjis_wait = 1'b1;
		end

		if (st.utf8_left != 2'd0) begin
			if (b < 8'h80 || b > 8'hbf)
				st.utf8_ok = 1'b0;
			st.utf8_left = st.utf8_left - 2'd1;
		end else if (b == 8'h00 || b inside {[8'h80:8'hc1]} || b >= 8'hf8) begin
			st.utf8_ok = 1'b0;
		end else if (b inside {[8'hc2:8'hdf]}) begin
			st.utf8_left = 2'd1;
		end else if (b inside {[8'he0:8'hef]}) begin
			st.utf8_left = 2'd2;
		end else if (b inside {[8'hf0:8'hf7]}) begin
			st.utf8_left = 2'd3;
		end

		if (st.cr_pend) begin
			if (st.cr_cnt != 2'd3) begin
				case (st.cr_cnt)
					2'd0: st.cr_la[7:0] = b;
					2'd1: st.cr_la[15:8] = b;
					default: st.cr_la[23:16] = b;
				endcase
				st.cr_cnt = st.cr_cnt + 2'd1;
			end
			st = cr_resolve(st, 1'b0);
		end else if (!st.nl_done) begin
			if (b == BYTE_LF) begin
				st.nl_done = 1'b1;
				st.nl_kind = NL_LF;
			end else if (b == BYTE_CR) begin
				st.nl_done = 1'b1;
				st.cr_pend = 1'b1;
				st.cr_odd = st.parity;
				st.cr_pz = st.prev_zero;
				st.cr_la = '0;
				st.cr_cnt = 2'd0;
			end
		end
		st.prev_zero = (b == 8'h00);
		st.parity = ~st.parity;
		return st;
	endfunction

endpackage

// ----- hw/rtl/ted_step.sv -----
// next-state and verdict logic for one accepted byte
module ted_step (
	input  ted_pkg::det_state_t cur,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output ted_pkg::det_state_t nxt,
	output ted_pkg::result_t    res
);

	ted_pkg::det_state_t fed;
	ted_pkg::det_state_t fin;
	logic       sjis_acc;
	logic       utf8_acc;

	always_comb begin
		fed = cur;
		if (cur.cnt != 2'd3) begin
			case (cur.cnt)
				2'd0: fed.head[7:0] = data_byte;
				2'd1: fed.head[15:8] = data_byte;
				default: fed.head[23:16] = data_byte;
			endcase
			fed.cnt = cur.cnt + 2'd1;
			if (fed.cnt == 2'd3) begin
				// header complete: first matching mark wins
				if (fed.head[7:0] == 8'hff && fed.head[15:8] == 8'hfe) begin
					fed.bom = ted_pkg::BOM_LE;
					fed = ted_pkg::body_feed(fed, fed.head[23:16]);
				end else if (fed.head[7:0] == 8'hfe && fed.head[15:8] == 8'hff) begin
					fed.bom = ted_pkg::BOM_BE;
					fed = ted_pkg::body_feed(fed, fed.head[23:16]);
				end else if (fed.head[7:0] == 8'hef && fed.head[15:8] == 8'hbb
						&& fed.head[23:16] == 8'hbf) begin
					fed.bom = ted_pkg::BOM_UTF8;
				end else begin
					fed = ted_pkg::body_feed(fed, fed.head[7:0]);
					fed = ted_pkg::body_feed(fed, fed.head[15:8]);
					fed = ted_pkg::body_feed(fed, fed.head[23:16]);
				end
			end
		end else begin
			fed = ted_pkg::body_feed(cur, data_byte);
		end
	end

	assign fin = ted_pkg::cr_resolve(fed, 1'b1);
	assign sjis_acc = fin.sjis_ok && !fin.sjis_wait;
	assign utf8_acc = fin.utf8_ok && (fin.utf8_left == 2'd0);

	always_comb begin
		res = '0;
		if (fed.cnt == 2'd3) begin
			res.newline_type = fin.nl_kind;
			case (fin.bom)
				ted_pkg::BOM_LE: begin
					res.detected = 1'b1;
					res.encoding = ted_pkg::ENC_LE_BOM;
				end
				ted_pkg::BOM_BE: begin
					res.detected = 1'b1;
					res.encoding = ted_pkg::ENC_BE_BOM;
				end
				ted_pkg::BOM_UTF8: begin
					res.detected = 1'b1;
					res.encoding = ted_pkg::ENC_UTF8_BOM;
				end
				default: begin
					if (utf8_acc && !sjis_acc) begin
						res.detected = 1'b1;
						res.encoding = ted_pkg::ENC_UTF8;
					end else if (sjis_acc && !utf8_acc) begin
						res.detected = 1'b1;
						res.encoding = ted_pkg::ENC_SJIS;
					end else if (fin.hint == ted_pkg::HINT_LE) begin
						res.encoding = ted_pkg::ENC_LE_GUESS;
					end else if (fin.hint == ted_pkg::HINT_BE) begin
						res.encoding = ted_pkg::ENC_BE_GUESS;
					end
				end
			endcase
		end
	end

	// a result closes the stream and returns everything to reset
	assign nxt = last_byte ? ted_pkg::state_reset() : fed;

endmodule

// ----- hw/rtl/text_encoding_newline_detector.sv -----
// top level of the text encoding and newline detector
// Takes one byte of a text stream per cycle on the byte channel while byte_ready is high,
// with last_byte on the final byte, and returns one verdict per stream on the result
// channel: a leading byte order mark (UTF-16LE, UTF-16BE, UTF-8) decides at once,
// otherwise Shift-JIS and UTF-8 validators run side by side and the encoding is detected
// only if exactly one accepts; the first newline (CRLF, CR, LF) is reported, and a zero
// beside the first CR can give an undecided stream a UTF-16 byte order guess. Streams
// under 3 bytes report detected 0. The state register is updated by one combinational
// pass per byte, and the verdict is registered into a two-entry result buffer, which
// keeps byte_ready high while one verdict waits; byte_ready drops only when two verdicts
// are queued. State returns to reset after each verdict, so the next byte starts a new
// stream.
module text_encoding_newline_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       detected,
	output logic [2:0] encoding,
	output logic [1:0] newline_type
);

	ted_pkg::det_state_t st_q;
	ted_pkg::det_state_t st_nxt;
	ted_pkg::result_t    res_nxt;
	ted_pkg::result_t    out_q;
	ted_pkg::result_t    skid_q;
	logic                out_v_q;
	logic                skid_v_q;
	logic                take;
	logic                new_res;
	logic                pop;

	ted_step u_step (
		.cur       (st_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.nxt       (st_nxt),
		.res       (res_nxt)
	);

	assign byte_ready = !skid_v_q;
	assign take = byte_valid && byte_ready;
	assign new_res = take && last_byte;
	assign pop = out_v_q && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ted_pkg::state_reset();
		end else if (take) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || pop) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= new_res;
				end
			end else if (new_res) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (new_res)
				out_q <= res_nxt;
		end else if (new_res) begin
			skid_q <= res_nxt;
		end
	end

	assign result_valid = out_v_q;
	assign detected = out_q.detected;
	assign encoding = out_q.encoding;
	assign newline_type = out_q.newline_type;

endmodule

// ----- tb/tb.sv -----
// testbench for the text encoding and newline detector: directed and random byte streams against a predictor
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_beat_t;

	localparam int CALM_TAIL = 60;
	localparam int RANDOM_BYTES = 520;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic       detected;
	logic [2:0] encoding;
	logic [1:0] newline_type;

	text_encoding_newline_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.detected(detected),
		.encoding(encoding),
		.newline_type(newline_type)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	byte_beat_t          byte_q[$];
	logic [7:0]          text_buf[$];
	ted_pkg::result_t    verdict_q[$];
	byte_beat_t          beat;
	ted_pkg::result_t    want;
	ted_pkg::result_t    got;

	int bytes_sent = 0;
	int bytes_taken = 0;
	int gap_left = 0;
	int stall_left = 0;
	int fail_count = 0;
	int stim_bytes = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int mode_timer = 0;
	bit calm = 1'b0;

	// predictor state for the stream in progress
	logic [23:0] lead_bytes;
	logic [1:0]  lead_cnt;
	logic [1:0]  mark;
	bit          sj_ok;
	bit          sj_wait;
	bit          u8_ok;
	logic [1:0]  u8_left;
	bit          nl_seen;
	logic [1:0]  nl_code;
	logic [23:0] after_cr;
	logic [1:0]  after_cnt;
	bit          cr_open;
	bit          cr_odd_pos;
	bit          cr_zero_before;
	logic [1:0]  guess;
	bit          odd_pos;
	bit          zero_before;

	task automatic clear_stream();
		lead_bytes = '0;
		lead_cnt = 2'd0;
		mark = ted_pkg::BOM_NONE;
		sj_ok = 1'b1;
		sj_wait = 1'b0;
		u8_ok = 1'b1;
		u8_left = 2'd0;
		nl_seen = 1'b0;
		nl_code = ted_pkg::NL_NONE;
		after_cr = '0;
		after_cnt = 2'd0;
		cr_open = 1'b0;
		cr_odd_pos = 1'b0;
		cr_zero_before = 1'b0;
		guess = ted_pkg::HINT_NONE;
		odd_pos = 1'b0;
		zero_before = 1'b0;
	endtask

	// decide a pending CR from the bytes seen after it
	task automatic settle_cr(input bit at_end);
		logic [7:0] n1;
		logic [7:0] n2;
		logic [7:0] n3;
		logic [1:0] kind;
		logic [1:0] hint;
		bit         done;
		n1 = after_cr[7:0];
		n2 = after_cr[15:8];
		n3 = after_cr[23:16];
		kind = ted_pkg::NL_NONE;
		hint = ted_pkg::HINT_NONE;
		done = 1'b0;
		if (cr_open) begin
			if (after_cnt >= 1 && n1 == ted_pkg::BYTE_LF) begin
				kind = ted_pkg::NL_CRLF;
				done = 1'b1;
			end else if (after_cnt >= 2 && n1 == 8'h00 && n2 == ted_pkg::BYTE_LF) begin
				kind = ted_pkg::NL_CRLF;
				if (cr_odd_pos) begin
					hint = cr_zero_before ? ted_pkg::HINT_BE : ted_pkg::HINT_NONE;
					done = 1'b1;
				end else if (after_cnt == 3) begin
					hint = (n3 == 8'h00) ? ted_pkg::HINT_LE : ted_pkg::HINT_NONE;
					done = 1'b1;
				end else begin
					done = at_end;
				end
			end else if (!at_end && (after_cnt == 0 || (after_cnt == 1 && n1 == 8'h00))) begin
				done = 1'b0;
			end else begin
				kind = ted_pkg::NL_CR;
				if (cr_odd_pos)
					hint = cr_zero_before ? ted_pkg::HINT_BE : ted_pkg::HINT_NONE;
				else
					hint = (after_cnt >= 1 && n1 == 8'h00) ? ted_pkg::HINT_LE
						: ted_pkg::HINT_NONE;
				done = 1'b1;
			end
			if (done) begin
				nl_code = kind;
				guess = hint;
				cr_open = 1'b0;
			end
		end
	endtask

	task automatic feed_body(input logic [7:0] b);
		if (sj_wait) begin
			sj_wait = 1'b0;
			if (b < 8'h40 || b == 8'h7f || b > 8'hfc)
				sj_ok = 1'b0;
		end else if (b == 8'h00 || (b >= 8'ha1 && b <= 8'hdf)) begin
			sj_ok = 1'b0;
		end else if ((b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc)) begin
			sj_wait = 1'b1;
		end

		if (u8_left != 2'd0) begin
			if (b[7:6] != 2'b10)
				u8_ok = 1'b0;
			u8_left = u8_left - 2'd1;
		end else if (b == 8'h00 || (b >= 8'h80 && b <= 8'hc1) || b >= 8'hf8) begin
			u8_ok = 1'b0;
		end else if (b >= 8'hf0) begin
			u8_left = 2'd3;
		end else if (b >= 8'he0) begin
			u8_left = 2'd2;
		end else if (b >= 8'hc2) begin
			u8_left = 2'd1;
		end

		if (cr_open) begin
			// up to three bytes after the CR are kept for the decision
			if (after_cnt != 2'd3) begin
				after_cr[8 * after_cnt +: 8] = b;
				after_cnt = after_cnt + 2'd1;
			end
			settle_cr(1'b0);
		end else if (!nl_seen) begin
			if (b == ted_pkg::BYTE_LF) begin
				nl_seen = 1'b1;
				nl_code = ted_pkg::NL_LF;
			end else if (b == ted_pkg::BYTE_CR) begin
				nl_seen = 1'b1;
				cr_open = 1'b1;
				cr_odd_pos = odd_pos;
				cr_zero_before = zero_before;
				after_cr = '0;
				after_cnt = 2'd0;
			end
		end
		zero_before = (b == 8'h00);
		odd_pos = !odd_pos;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic fin);
		ted_pkg::result_t v;
		bit      sj_accept;
		bit      u8_accept;
		if (lead_cnt != 2'd3) begin
			lead_bytes[8 * lead_cnt +: 8] = b;
			lead_cnt = lead_cnt + 2'd1;
			if (lead_cnt == 2'd3) begin
				// only the first matching mark counts
				if (lead_bytes[15:0] == 16'hfeff) begin
					mark = ted_pkg::BOM_LE;
					feed_body(lead_bytes[23:16]);
				end else if (lead_bytes[15:0] == 16'hfffe) begin
					mark = ted_pkg::BOM_BE;
					feed_body(lead_bytes[23:16]);
				end else if (lead_bytes == 24'hbfbbef) begin
					mark = ted_pkg::BOM_UTF8;
				end else begin
					feed_body(lead_bytes[7:0]);
					feed_body(lead_bytes[15:8]);
					feed_body(lead_bytes[23:16]);
				end
			end
		end else begin
			feed_body(b);
		end

		if (fin) begin
			v = '0;
			if (lead_cnt == 2'd3) begin
				settle_cr(1'b1);
				v.newline_type = nl_code;
				case (mark)
					ted_pkg::BOM_LE: begin
						v.detected = 1'b1;
						v.encoding = ted_pkg::ENC_LE_BOM;
					end
					ted_pkg::BOM_BE: begin
						v.detected = 1'b1;
						v.encoding = ted_pkg::ENC_BE_BOM;
					end
					ted_pkg::BOM_UTF8: begin
						v.detected = 1'b1;
						v.encoding = ted_pkg::ENC_UTF8_BOM;
					end
					default: begin
						sj_accept = sj_ok && !sj_wait;
						u8_accept = u8_ok && u8_left == 2'd0;
						if (sj_accept != u8_accept) begin
							v.detected = 1'b1;
							v.encoding = u8_accept ? ted_pkg::ENC_UTF8 : ted_pkg::ENC_SJIS;
						end else if (guess == ted_pkg::HINT_LE) begin
							v.encoding = ted_pkg::ENC_LE_GUESS;
						end else if (guess == ted_pkg::HINT_BE) begin
							v.encoding = ted_pkg::ENC_BE_GUESS;
						end
					end
				endcase
			end
			verdict_q.push_back(v);
			clear_stream();
		end
	endtask

	task automatic ship_stream();
		byte_beat_t bt;
		if (text_buf.size() != 0) begin
			foreach (text_buf[i]) begin
				bt.data = text_buf[i];
				bt.last = (i == text_buf.size() - 1);
				byte_q.push_back(bt);
			end
			stim_bytes += text_buf.size();
			text_buf.delete();
		end
	endtask

	// bytes are listed first byte leftmost
	task automatic directed(input logic [47:0] w, input int n);
		for (int i = n - 1; i >= 0; i--)
			text_buf.push_back(w[8 * i +: 8]);
		ship_stream();
	endtask

	task automatic put_newline();
		case ($urandom_range(0, 2))
			0: text_buf.push_back(ted_pkg::BYTE_LF);
			1: text_buf.push_back(ted_pkg::BYTE_CR);
			default: begin
				text_buf.push_back(ted_pkg::BYTE_CR);
				text_buf.push_back(ted_pkg::BYTE_LF);
			end
		endcase
	endtask

	task automatic put_ascii();
		if ($urandom_range(0, 7) == 0)
			put_newline();
		else
			text_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
	endtask

	task automatic put_utf8_char();
		int n;
		n = $urandom_range(0, 3);
		case (n)
			0: put_ascii();
			1: text_buf.push_back(8'($urandom_range(8'hc2, 8'hdf)));
			2: text_buf.push_back(8'($urandom_range(8'he0, 8'hef)));
			default: text_buf.push_back(8'($urandom_range(8'hf0, 8'hf7)));
		endcase
		repeat (n) text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
	endtask

	task automatic put_sjis_char();
		if ($urandom_range(0, 1) == 0) begin
			put_ascii();
		end else begin
			if ($urandom_range(0, 1) == 0)
				text_buf.push_back(8'($urandom_range(8'h81, 8'h9f)));
			else
				text_buf.push_back(8'($urandom_range(8'he0, 8'hfc)));
			if ($urandom_range(0, 1) == 0)
				text_buf.push_back(8'($urandom_range(8'h40, 8'h7e)));
			else
				text_buf.push_back(8'($urandom_range(8'h80, 8'hfc)));
		end
	endtask

	task automatic put_u16_unit(input logic [7:0] c, input bit big);
		if (big) begin
			text_buf.push_back(8'h00);
			text_buf.push_back(c);
		end else begin
			text_buf.push_back(c);
			text_buf.push_back(8'h00);
		end
	endtask

	// break a well-formed stream now and then
	task automatic maybe_damage();
		case ($urandom_range(0, 7))
			0: if (text_buf.size() != 0)
				text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
			1: if (text_buf.size() > 1)
				void'(text_buf.pop_back());
			default: ;
		endcase
	endtask

	task automatic report_bad(input string what, input ted_pkg::result_t exp_v,
			input ted_pkg::result_t act_v);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %0s: expected %0d %0d %0d, actual %0d %0d %0d",
				$realtime, what, exp_v.detected, exp_v.encoding, exp_v.newline_type,
				act_v.detected, act_v.encoding, act_v.newline_type);
	endtask

	// idling pattern changes at random intervals, and goes away near the end
	always @(posedge clk) begin
		calm = (byte_q.size() < CALM_TAIL);
		if (mode_timer == 0) begin
			mode_timer = $urandom_range(20, 80);
			idle_pct = 15 * $urandom_range(0, 3);
			stall_pct = 15 * $urandom_range(0, 3);
		end else begin
			mode_timer--;
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (arst_n && bytes_taken == bytes_sent) begin
			if (gap_left != 0) begin
				gap_left--;
				byte_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				beat = byte_q.pop_front();
				byte_valid <= 1'b1;
				data_byte <= beat.data;
				last_byte <= beat.last;
				bytes_sent++;
				if (!calm && $urandom_range(0, 99) < idle_pct)
					gap_left = $urandom_range(1, 7);
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 6);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// monitor: predict on each byte beat, check each verdict beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				predict_byte(data_byte, last_byte);
				bytes_taken++;
			end
			if (result_valid && result_ready) begin
				got = {detected, encoding, newline_type};
				if (verdict_q.size() == 0) begin
					report_bad("verdict with none pending", '0, got);
				end else begin
					want = verdict_q.pop_front();
					if (got.detected !== want.detected || got.encoding !== want.encoding ||
							got.newline_type !== want.newline_type)
						report_bad("verdict mismatch", want, got);
				end
			end
		end
	end

	initial begin
		int  random_goal;
		bit  big;
		int  n;
		logic [7:0] pick;

		clear_stream();

		directed(48'h00, 1);
		directed(48'hfffe, 2);
		directed(48'hefbbbf, 3);
		directed(48'hfeff0d, 3);
		directed(48'h0d000a00, 4);
		directed(48'h000d41, 3);
		directed(48'h8140fcfc0a, 5);
		directed(48'hf7bfbfbf7f, 5);
		directed(48'hffffff, 3);

		random_goal = stim_bytes + RANDOM_BYTES;
		while (stim_bytes < random_goal) begin
			case ($urandom_range(0, 11))
				0: begin
					// streams too short to be detected
					repeat ($urandom_range(1, 2)) text_buf.push_back(8'($urandom_range(0, 255)));
				end
				1, 2: begin
					repeat ($urandom_range(2, 10)) put_utf8_char();
					maybe_damage();
				end
				3: begin
					text_buf.push_back(8'hef);
					text_buf.push_back(8'hbb);
					text_buf.push_back(8'hbf);
					repeat ($urandom_range(0, 6)) put_utf8_char();
				end
				4, 5: begin
					repeat ($urandom_range(2, 10)) put_sjis_char();
					maybe_damage();
				end
				6, 7, 8: begin
					big = $urandom_range(0, 1);
					if ($urandom_range(0, 2) == 0) begin
						text_buf.push_back(big ? 8'hfe : 8'hff);
						text_buf.push_back(big ? 8'hff : 8'hfe);
					end
					// shift the unit alignment now and then
					if ($urandom_range(0, 3) == 0)
						text_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
					repeat ($urandom_range(2, 8)) begin
						case ($urandom_range(0, 7))
							0: put_u16_unit(ted_pkg::BYTE_CR, big);
							1: put_u16_unit(ted_pkg::BYTE_LF, big);
							2: begin
								put_u16_unit(ted_pkg::BYTE_CR, big);
								put_u16_unit(ted_pkg::BYTE_LF, big);
							end
							default: put_u16_unit(8'($urandom_range(8'h20, 8'h7e)), big);
						endcase
					end
					if ($urandom_range(0, 3) == 0)
						void'(text_buf.pop_back());
				end
				9: begin
					// CR followed by a cut-off zero / LF / zero tail
					repeat ($urandom_range(0, 3))
						text_buf.push_back(($urandom_range(0, 1) == 0) ? 8'h00
							: 8'($urandom_range(8'h20, 8'h7e)));
					text_buf.push_back(ted_pkg::BYTE_CR);
					n = $urandom_range(0, 4);
					for (int i = 0; i < n; i++) begin
						case (i)
							0, 2: pick = 8'h00;
							1: pick = ted_pkg::BYTE_LF;
							default: pick = 8'h41;
						endcase
						if ($urandom_range(0, 3) == 0) begin
							case ($urandom_range(0, 3))
								0: pick = 8'h00;
								1: pick = ted_pkg::BYTE_LF;
								2: pick = ted_pkg::BYTE_CR;
								default: pick = 8'h41;
							endcase
						end
						text_buf.push_back(pick);
					end
				end
				default: begin
					repeat ($urandom_range(3, 16)) text_buf.push_back(8'($urandom_range(0, 255)));
				end
			endcase
			ship_stream();
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (byte_q.size() == 0 && bytes_taken == bytes_sent && verdict_q.size() == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
